### rtl/core/hsr_pkg.sv
// ----------------------------------------------------------------------------
// hsr_pkg: shared types and constants of the HSMS session receiver
// Command, operation and event codes, register map, header layout and the
// structs that travel between the front, the queue and the back end.
// ----------------------------------------------------------------------------
package hsr_pkg;

  localparam int TIMER_WIDTH = 16;
  localparam int CFG_TMO_W   = 16;
  localparam int CMP_W       = (TIMER_WIDTH > CFG_TMO_W) ? TIMER_WIDTH : CFG_TMO_W;
  localparam int QUEUE_DEPTH = 2;
  localparam int APB_ADDR_W  = 5;

  localparam logic [2:0] PREFIX_LEN = 3'd4;
  localparam logic [3:0] HDR_LEN    = 4'd10;

  localparam logic [7:0] STYPE_DATA         = 8'd0;
  localparam logic [7:0] STYPE_SELECT_RSP   = 8'd2;
  localparam logic [7:0] STYPE_DESELECT_RSP = 8'd4;
  localparam logic [7:0] STYPE_LINKTEST_RSP = 8'd6;
  localparam logic [7:0] STYPE_SEPARATE     = 8'd9;

  typedef enum logic [1:0] {
    CMD_CONNECT = 2'd0,
    CMD_BYTE    = 2'd1,
    CMD_TICK    = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_code_t;

  typedef enum logic [1:0] {
    OP_CONNECT = 2'd0,
    OP_BYTE    = 2'd1,
    OP_TICK    = 2'd2
  } op_code_t;

  typedef enum logic [2:0] {
    EV_DATA_HDR      = 3'd0,
    EV_PAYLOAD       = 3'd1,
    EV_DISCONNECT    = 3'd2,
    EV_SEND_SELECT   = 3'd3,
    EV_SEND_LINKTEST = 3'd4,
    EV_SELECTED      = 3'd5,
    EV_DESELECTED    = 3'd6
  } event_t;

  typedef enum logic [2:0] {
    REG_OWN_SESSION       = 3'd0,
    REG_SELECT_TIMEOUT    = 3'd1,
    REG_ALIVE_TIMEOUT     = 3'd2,
    REG_LINKTEST_INTERVAL = 3'd3,
    REG_INITIAL_SYSTEM    = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] own_session;
    logic [15:0] select_timeout;
    logic [15:0] alive_timeout;
    logic [15:0] linktest_interval;
    logic [31:0] initial_system;
  } cfg_t;

  typedef struct packed {
    op_code_t   op;
    logic [7:0] data;
  } op_t;

  typedef struct packed {
    event_t      event_res;
    logic [15:0] peer_session;
    logic [6:0]  stream_no;
    logic [7:0]  function_no;
    logic        reply_wanted;
    logic [31:0] system_word;
    logic [7:0]  payload_byte;
    logic        last_of_message;
  } result_t;

  typedef struct packed {
    logic   linked;
    logic   sel_on;
    logic   alive_on;
    logic   res_load;
    event_t res_event;
  } status_t;

endpackage

### rtl/core/hsr_intf.sv
// ----------------------------------------------------------------------------
// hsr_intf: word channels of the HSMS session receiver
// Command channel (connect, byte, tick) and event channel, valid/ready.
// ----------------------------------------------------------------------------
interface hsr_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] data_byte;

  modport source (output valid, command, data_byte, input ready);
  modport sink (input valid, command, data_byte, output ready);
endinterface

interface hsr_evt_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [15:0] peer_session;
  logic [6:0]  stream_no;
  logic [7:0]  function_no;
  logic        reply_wanted;
  logic [31:0] system_word;
  logic [7:0]  payload_byte;
  logic        last_of_message;

  modport source (output valid, event_res, peer_session, stream_no, function_no,
                  reply_wanted, system_word, payload_byte, last_of_message,
                  input ready);
  modport sink (input valid, event_res, peer_session, stream_no, function_no,
                reply_wanted, system_word, payload_byte, last_of_message,
                output ready);
endinterface

### rtl/core/hsms_session_receiver_unit.sv
// ----------------------------------------------------------------------------
// hsms_session_receiver_unit: host side HSMS session receiver
// Command intake, operation queue, session engine and APB register file.
//
//   channel   dir  word                          handshake
//   cmd       in   command, data_byte            valid/ready
//   evt       out  event_res .. last_of_message  valid/ready
//   apb       in   own_session .. initial_system psel/penable, pready high
//
// One word per cycle sustained while evt.ready holds; the session engine
// retires one queued operation per cycle unless the event register stalls,
// set by its single state update loop. evt.valid rises once an accepted
// command word has passed the intake stage, a queue slot and the event register.
// Connect words are never dropped; command code 3 is dropped at intake.
// Reset is synchronous; the register file returns to its reset values.
// An event stall fills the queue, then drops cmd.ready.
// ----------------------------------------------------------------------------
module hsms_session_receiver_unit
  import hsr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  hsr_cmd_if.sink               cmd,
  hsr_evt_if.source             evt,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  cfg_t     cfg;
  reg_idx_t reg_idx;
  logic     wr_en;
  logic     f_valid;
  logic     f_ready;
  op_t      f_op;
  logic     q_valid;
  logic     q_ready;
  op_t      q_op;
  status_t  st;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[4:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.own_session       <= 16'd0;
      cfg.select_timeout    <= 16'd1000;
      cfg.alive_timeout     <= 16'd3000;
      cfg.linktest_interval <= 16'd1000;
      cfg.initial_system    <= 32'd0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_OWN_SESSION:       cfg.own_session       <= pwdata[15:0];
        REG_SELECT_TIMEOUT:    cfg.select_timeout    <= pwdata[15:0];
        REG_ALIVE_TIMEOUT:     cfg.alive_timeout     <= pwdata[15:0];
        REG_LINKTEST_INTERVAL: cfg.linktest_interval <= pwdata[15:0];
        REG_INITIAL_SYSTEM:    cfg.initial_system    <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_OWN_SESSION:       prdata = {16'd0, cfg.own_session};
      REG_SELECT_TIMEOUT:    prdata = {16'd0, cfg.select_timeout};
      REG_ALIVE_TIMEOUT:     prdata = {16'd0, cfg.alive_timeout};
      REG_LINKTEST_INTERVAL: prdata = {16'd0, cfg.linktest_interval};
      REG_INITIAL_SYSTEM:    prdata = cfg.initial_system;
      default:               prdata = 32'd0;
    endcase
  end

  hsr_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .f_valid (f_valid),
    .f_ready (f_ready),
    .f_op    (f_op)
  );

  hsr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_op    (f_op),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_op     (q_op)
  );

  hsr_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_op    (q_op),
    .evt     (evt),
    .status  (st)
  );

  a_timers_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(st.sel_on && st.alive_on))
    else $error("select and alive timers both running");

  a_timers_need_link: assert property (@(posedge clk) disable iff (rst)
    (st.sel_on || st.alive_on) |-> st.linked)
    else $error("timer running while not linked");

  a_disconnect_unlinks: assert property (@(posedge clk) disable iff (rst)
    (st.res_load && st.res_event == EV_DISCONNECT) |=> !st.linked)
    else $error("link still up after disconnect event");

  a_connect_selects: assert property (@(posedge clk) disable iff (rst)
    (st.res_load && st.res_event == EV_SEND_SELECT) |=> (st.linked && st.sel_on))
    else $error("select timer not started after connect");

endmodule

### rtl/core/hsr_front.sv
// ----------------------------------------------------------------------------
// hsr_front: command intake
// Accepts command words, decodes them into operations, drops unused codes,
// and holds one operation in a register stage for the queue.
// ----------------------------------------------------------------------------
module hsr_front
  import hsr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  hsr_cmd_if.sink   cmd,
  output logic      f_valid,
  input  logic      f_ready,
  output op_t       f_op
);

  op_code_t op_next;
  logic     keep;

  always_comb begin
    cmd.ready = !f_valid || f_ready;
    keep      = 1'b1;
    op_next   = OP_CONNECT;
    case (cmd_code_t'(cmd.command))
      CMD_CONNECT: op_next = OP_CONNECT;
      CMD_BYTE:    op_next = OP_BYTE;
      CMD_TICK:    op_next = OP_TICK;
      default:     keep = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (cmd.ready) begin
      f_valid <= cmd.valid && keep;
    end
    if (cmd.ready && cmd.valid) begin
      f_op.op   <= op_next;
      f_op.data <= cmd.data_byte;
    end
  end

endmodule

### rtl/core/hsr_queue.sv
// ----------------------------------------------------------------------------
// hsr_queue: operation queue
// Short FIFO between the command intake and the session engine.
// ----------------------------------------------------------------------------
module hsr_queue
  import hsr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  op_t  push_op,
  output logic pop_valid,
  input  logic pop_ready,
  output op_t  pop_op
);

  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  op_t               slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  assign push_ready = count != QCNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_op     = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

endmodule

### rtl/core/hsr_back.sv
// ----------------------------------------------------------------------------
// hsr_back: session engine
// Deframes received bytes, decodes headers, runs the select, alive and
// link test timers, and drives the event output register.
// ----------------------------------------------------------------------------
module hsr_back
  import hsr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      q_valid,
  output logic      q_ready,
  input  op_t       q_op,
  hsr_evt_if.source evt,
  output status_t   status
);

  function automatic logic [TIMER_WIDTH-1:0] timer_inc(input logic [TIMER_WIDTH-1:0] t);
    return (t == '1) ? t : t + 1'b1;
  endfunction

  logic                   linked, linked_next;
  logic [31:0]            len_shift, len_shift_next;
  logic [2:0]             pfx_cnt, pfx_cnt_next;
  logic [31:0]            bytes_left, bytes_left_next;
  logic [7:0]             hdr [HDR_LEN];
  logic [3:0]             hdr_cnt, hdr_cnt_next;
  logic                   drop_body, drop_body_next;
  logic                   sel_on, sel_on_next;
  logic [TIMER_WIDTH-1:0] sel_tmr, sel_tmr_next;
  logic                   alive_on, alive_on_next;
  logic [TIMER_WIDTH-1:0] alive_tmr, alive_tmr_next;
  logic [TIMER_WIDTH-1:0] lt_tmr, lt_tmr_next;
  logic [31:0]            sys_cnt, sys_cnt_next;

  logic                   out_valid;
  result_t                res_q;
  result_t                res;
  result_t                hres;
  logic                   res_hit;
  logic                   take;
  logic                   hdr_we;
  logic                   do_disc;
  logic [7:0]             b;
  logic [31:0]            len_cat;
  logic [2:0]             pfx_inc;
  logic [31:0]            bl_dec;
  logic                   bl_zero;
  logic                   hdr_fin;
  logic                   mine;
  logic [31:0]            sys_inc;
  logic [31:0]            init_inc;
  logic [TIMER_WIDTH-1:0] sel_inc, alive_inc, lt_inc;

  assign q_ready = !out_valid || evt.ready;
  assign take    = q_valid && q_ready;

  always_comb begin
    linked_next     = linked;
    len_shift_next  = len_shift;
    pfx_cnt_next    = pfx_cnt;
    bytes_left_next = bytes_left;
    hdr_cnt_next    = hdr_cnt;
    drop_body_next  = drop_body;
    sel_on_next     = sel_on;
    sel_tmr_next    = sel_tmr;
    alive_on_next   = alive_on;
    alive_tmr_next  = alive_tmr;
    lt_tmr_next     = lt_tmr;
    sys_cnt_next    = sys_cnt;
    hdr_we          = 1'b0;
    do_disc         = 1'b0;
    res_hit         = 1'b0;
    res             = '0;

    b         = q_op.data;
    len_cat   = {len_shift[23:0], b};
    pfx_inc   = pfx_cnt + 1'b1;
    bl_dec    = bytes_left - 32'd1;
    bl_zero   = bl_dec == 32'd0;
    hdr_fin   = hdr_cnt == HDR_LEN - 4'd1;
    sys_inc   = sys_cnt + 32'd1;
    init_inc  = cfg.initial_system + 32'd1;
    sel_inc   = timer_inc(sel_tmr);
    alive_inc = timer_inc(alive_tmr);
    lt_inc    = timer_inc(lt_tmr);
    mine      = {hdr[0], hdr[1]} == cfg.own_session;

    hres                 = '0;
    hres.peer_session    = {hdr[0], hdr[1]};
    hres.stream_no       = hdr[2][6:0];
    hres.function_no     = hdr[3];
    hres.reply_wanted    = hdr[2][7];
    hres.system_word     = {hdr[6], hdr[7], hdr[8], hdr_fin ? b : hdr[9]};

    case (q_op.op)
      OP_CONNECT: begin
        linked_next      = 1'b1;
        len_shift_next   = '0;
        pfx_cnt_next     = '0;
        bytes_left_next  = '0;
        drop_body_next   = 1'b0;
        sys_cnt_next     = init_inc;
        sel_on_next      = 1'b1;
        sel_tmr_next     = '0;
        alive_on_next    = 1'b0;
        alive_tmr_next   = '0;
        lt_tmr_next      = '0;
        res_hit          = 1'b1;
        res.event_res    = EV_SEND_SELECT;
        res.peer_session = cfg.own_session;
        res.system_word  = init_inc;
      end
      OP_BYTE: begin
        if (linked) begin
          if (pfx_cnt < PREFIX_LEN) begin
            len_shift_next = len_cat;
            pfx_cnt_next   = pfx_inc;
            if (pfx_inc == PREFIX_LEN) begin
              if (len_cat < 32'(HDR_LEN)) begin
                do_disc = 1'b1;
              end else begin
                bytes_left_next = len_cat;
                drop_body_next  = 1'b0;
                hdr_cnt_next    = '0;
              end
            end
          end else begin
            bytes_left_next = bl_dec;
            if (hdr_cnt != HDR_LEN) begin
              hdr_we       = 1'b1;
              hdr_cnt_next = hdr_cnt + 1'b1;
              if (hdr_fin) begin
                if (hdr[5] == STYPE_DATA) begin
                  drop_body_next = !mine;
                  if (mine) begin
                    res_hit              = 1'b1;
                    res                  = hres;
                    res.event_res        = EV_DATA_HDR;
                    res.last_of_message  = bl_zero;
                  end
                end else begin
                  drop_body_next = 1'b1;
                  if (!mine) begin
                    do_disc = 1'b1;
                  end else begin
                    case (hdr[5])
                      STYPE_SELECT_RSP: begin
                        sel_on_next    = 1'b0;
                        alive_on_next  = 1'b1;
                        alive_tmr_next = '0;
                        res_hit        = 1'b1;
                        res            = hres;
                        res.event_res  = EV_SELECTED;
                      end
                      STYPE_DESELECT_RSP: begin
                        alive_on_next  = 1'b0;
                        sel_on_next    = 1'b1;
                        sel_tmr_next   = '0;
                        res_hit        = 1'b1;
                        res            = hres;
                        res.event_res  = EV_DESELECTED;
                      end
                      STYPE_LINKTEST_RSP: alive_tmr_next = '0;
                      STYPE_SEPARATE:     do_disc = 1'b1;
                      default: ;
                    endcase
                  end
                end
              end
            end else if (!drop_body) begin
              res_hit             = 1'b1;
              res                 = hres;
              res.event_res       = EV_PAYLOAD;
              res.payload_byte    = b;
              res.last_of_message = bl_zero;
            end
            if (bl_zero) begin
              len_shift_next = '0;
              pfx_cnt_next   = '0;
            end
          end
        end
      end
      OP_TICK: begin
        if (linked) begin
          if (sel_on) begin
            sel_tmr_next = sel_inc;
          end
          if (sel_on && (CMP_W'(sel_inc) >= CMP_W'(cfg.select_timeout))) begin
            do_disc = 1'b1;
          end else begin
            if (alive_on) begin
              alive_tmr_next = alive_inc;
            end
            if (alive_on && (CMP_W'(alive_inc) >= CMP_W'(cfg.alive_timeout))) begin
              do_disc = 1'b1;
            end else if (CMP_W'(lt_inc) > CMP_W'(cfg.linktest_interval)) begin
              lt_tmr_next      = '0;
              sys_cnt_next     = sys_inc;
              res_hit          = 1'b1;
              res.event_res    = EV_SEND_LINKTEST;
              res.peer_session = cfg.own_session;
              res.system_word  = sys_inc;
            end else begin
              lt_tmr_next = lt_inc;
            end
          end
        end
      end
      default: ;
    endcase

    if (do_disc) begin
      linked_next     = 1'b0;
      len_shift_next  = '0;
      pfx_cnt_next    = '0;
      bytes_left_next = '0;
      drop_body_next  = 1'b0;
      sel_on_next     = 1'b0;
      alive_on_next   = 1'b0;
      res_hit         = 1'b1;
      res             = '0;
      res.event_res   = EV_DISCONNECT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      linked     <= 1'b0;
      len_shift  <= '0;
      pfx_cnt    <= '0;
      bytes_left <= '0;
      hdr_cnt    <= '0;
      drop_body  <= 1'b0;
      sel_on     <= 1'b0;
      sel_tmr    <= '0;
      alive_on   <= 1'b0;
      alive_tmr  <= '0;
      lt_tmr     <= '0;
      sys_cnt    <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (take) begin
        linked     <= linked_next;
        len_shift  <= len_shift_next;
        pfx_cnt    <= pfx_cnt_next;
        bytes_left <= bytes_left_next;
        hdr_cnt    <= hdr_cnt_next;
        drop_body  <= drop_body_next;
        sel_on     <= sel_on_next;
        sel_tmr    <= sel_tmr_next;
        alive_on   <= alive_on_next;
        alive_tmr  <= alive_tmr_next;
        lt_tmr     <= lt_tmr_next;
        sys_cnt    <= sys_cnt_next;
        out_valid  <= res_hit;
      end else if (evt.ready) begin
        out_valid <= 1'b0;
      end
    end
    if (take && hdr_we) begin
      hdr[hdr_cnt] <= b;
    end
    if (take && res_hit) begin
      res_q <= res;
    end
  end

  assign evt.valid           = out_valid;
  assign evt.event_res       = res_q.event_res;
  assign evt.peer_session    = res_q.peer_session;
  assign evt.stream_no       = res_q.stream_no;
  assign evt.function_no     = res_q.function_no;
  assign evt.reply_wanted    = res_q.reply_wanted;
  assign evt.system_word     = res_q.system_word;
  assign evt.payload_byte    = res_q.payload_byte;
  assign evt.last_of_message = res_q.last_of_message;

  assign status.linked    = linked;
  assign status.sel_on    = sel_on;
  assign status.alive_on  = alive_on;
  assign status.res_load  = take && res_hit;
  assign status.res_event = res.event_res;

endmodule
